// ----- hw/rtl/wsd_pkg.sv -----
// Shared types for the WebSocket frame deframer.
// Holds the result request record passed from the parser to the output buffer.
// No dependencies.
package wsd_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_data;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        was_masked;
    logic [63:0] payload_length;
    logic        first_of_frame;
    logic        last_of_frame;
  } res_t;

endpackage

// ----- hw/rtl/wsd_parser.sv -----
// Frame header parser and payload unmasker for the WebSocket frame deframer.
// Holds all per-frame state; produces at most one result request per byte.
// Depends on wsd_pkg.
module wsd_parser
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       emit,
  output res_t       res
);

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  logic [2:0]  phase, phase_next;
  logic        fin, fin_next;
  logic [3:0]  opcode, opcode_next;
  logic        masked, masked_next;
  logic [63:0] length_accum, length_accum_next;
  logic [3:0]  hdr_left, hdr_left_next;
  logic [31:0] mask_key, mask_key_next;
  logic [63:0] payload_left, payload_left_next;
  logic [1:0]  mask_index, mask_index_next;
  logic        at_first, at_first_next;

  logic [6:0]  code;
  logic        len_done;
  logic        start_payload;
  logic [7:0]  key_byte;
  logic        last;

  assign code = in_byte[6:0];

  always_comb begin
    unique case (mask_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign last = (payload_left <= 64'd1);

  always_comb begin
    phase_next        = phase;
    fin_next          = fin;
    opcode_next       = opcode;
    masked_next       = masked;
    length_accum_next = length_accum;
    hdr_left_next     = hdr_left;
    mask_key_next     = mask_key;
    payload_left_next = payload_left;
    mask_index_next   = mask_index;
    at_first_next     = at_first;
    len_done          = 1'b0;
    start_payload     = 1'b0;
    emit              = 1'b0;
    res.data_byte      = 8'd0;
    res.has_data       = 1'b0;
    res.first_of_frame = 1'b0;
    res.last_of_frame  = 1'b0;

    unique case (phase)
      PH_HDR1: begin
        masked_next = in_byte[7];
        if (code == LEN_CODE16 || code == LEN_CODE64) begin
          hdr_left_next     = (code == LEN_CODE16) ? EXT16_BYTES : EXT64_BYTES;
          length_accum_next = 64'd0;
          phase_next        = PH_EXT;
        end else begin
          length_accum_next = {57'd0, code};
          len_done          = 1'b1;
        end
      end
      PH_EXT: begin
        length_accum_next = {length_accum[55:0], in_byte};
        hdr_left_next     = hdr_left - 4'd1;
        len_done          = (hdr_left == 4'd1);
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], in_byte};
        hdr_left_next = hdr_left - 4'd1;
        start_payload = (hdr_left == 4'd1);
      end
      PH_DATA: begin
        emit               = 1'b1;
        res.data_byte      = in_byte ^ (masked ? key_byte : 8'd0);
        res.has_data       = 1'b1;
        res.first_of_frame = at_first;
        res.last_of_frame  = last;
        at_first_next      = 1'b0;
        mask_index_next    = mask_index + 2'd1;
        if (payload_left != 64'd0) begin
          payload_left_next = payload_left - 64'd1;
        end
        if (last) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        fin_next    = in_byte[7];
        opcode_next = in_byte[3:0];
        phase_next  = PH_HDR1;
      end
    endcase

    if (len_done) begin
      if (masked_next) begin
        hdr_left_next = KEY_BYTES;
        mask_key_next = 32'd0;
        phase_next    = PH_KEY;
      end else begin
        start_payload = 1'b1;
      end
    end

    if (start_payload) begin
      payload_left_next = length_accum_next;
      mask_index_next   = 2'd0;
      at_first_next     = 1'b1;
      if (length_accum_next == 64'd0) begin
        emit               = 1'b1;
        res.first_of_frame = 1'b1;
        res.last_of_frame  = 1'b1;
        phase_next         = PH_HDR0;
      end else begin
        phase_next = PH_DATA;
      end
    end

    res.fin_flag       = fin_next;
    res.frame_opcode   = opcode_next;
    res.was_masked     = masked_next;
    res.payload_length = length_accum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      fin          <= 1'b0;
      opcode       <= 4'd0;
      masked       <= 1'b0;
      length_accum <= 64'd0;
      hdr_left     <= 4'd0;
      mask_key     <= 32'd0;
      payload_left <= 64'd0;
      mask_index   <= 2'd0;
      at_first     <= 1'b1;
    end else if (accept) begin
      phase        <= phase_next;
      fin          <= fin_next;
      opcode       <= opcode_next;
      masked       <= masked_next;
      length_accum <= length_accum_next;
      hdr_left     <= hdr_left_next;
      mask_key     <= mask_key_next;
      payload_left <= payload_left_next;
      mask_index   <= mask_index_next;
      at_first     <= at_first_next;
    end
  end

endmodule

// ----- hw/rtl/wsd_out_buf.sv -----
// Two-entry output register with skid stage for the WebSocket frame deframer.
// Decouples result requests from downstream ready. Depends on wsd_pkg.
module wsd_out_buf
  import wsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic main_valid;
  logic skid_valid;
  res_t main_data;
  res_t skid_data;
  logic pop;

  assign ready     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          main_data  <= skid_data;
          skid_valid <= 1'b0;
        end else if (push) begin
          main_data <= push_data;
        end else begin
          main_valid <= 1'b0;
        end
      end else if (push) begin
        if (!main_valid) begin
          main_data  <= push_data;
          main_valid <= 1'b1;
        end else begin
          skid_data  <= push_data;
          skid_valid <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/websocket_frame_deframer.sv -----
// Top level of the WebSocket frame deframer.
// Instantiates wsd_parser and wsd_out_buf; depends on wsd_pkg.
//
// Accepts one raw stream byte per cycle while in_ready is high and returns,
// registered, an unmasked payload byte with its frame's header fields, or
// a single marker for a frame with no payload. Header bytes give no result.
// Each byte is handled in the cycle it is accepted by the parser logic, whose
// longest path is the 64-bit payload count decrement and compare; a two-entry
// output register keeps input accepted while one result waits downstream, so
// the sustained rate is one byte per cycle when the receiver takes each result.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic        has_data,
  output logic        fin_flag,
  output logic [3:0]  frame_opcode,
  output logic        was_masked,
  output logic [63:0] payload_length,
  output logic        first_of_frame,
  output logic        last_of_frame
);

  logic accept;
  logic emit;
  res_t res;
  res_t out_data;

  assign accept = in_valid && in_ready;

  wsd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .emit    (emit),
    .res     (res)
  );

  wsd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && emit),
    .push_data (res),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign data_byte      = out_data.data_byte;
  assign has_data       = out_data.has_data;
  assign fin_flag       = out_data.fin_flag;
  assign frame_opcode   = out_data.frame_opcode;
  assign was_masked     = out_data.was_masked;
  assign payload_length = out_data.payload_length;
  assign first_of_frame = out_data.first_of_frame;
  assign last_of_frame  = out_data.last_of_frame;

endmodule

// ----- bench/wsd_frame_checker.sv -----
// Frame length codes shared by the bench, and the result checker for the
// WebSocket frame deframer: predicts each result from accepted stream bytes.
// Depends on wsd_pkg.
package wsd_ws_codes;

  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

endpackage

module wsd_frame_checker
  import wsd_pkg::*;
  import wsd_ws_codes::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_data,
  input  logic        fin_flag,
  input  logic [3:0]  frame_opcode,
  input  logic        was_masked,
  input  logic [63:0] payload_length,
  input  logic        first_of_frame,
  input  logic        last_of_frame,
  output int          fail_count,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_HEAD0,
    ST_HEAD1,
    ST_EXTLEN,
    ST_KEY,
    ST_PAYLOAD
  } parse_state_e;

  parse_state_e phase;
  logic         fin_q;
  logic [3:0]   opc_q;
  logic         masked_q;
  logic [63:0]  len_acc;
  logic [3:0]   hdr_left;
  logic [31:0]  key_q;
  logic [63:0]  pay_left;
  logic [1:0]   key_idx;
  logic         first_q;

  bit           made;
  res_t         made_res;
  res_t         pending_results[$];
  int           mismatches = 0;

  function automatic res_t make_result(input logic [7:0] d, input logic has,
                                       input logic first, input logic last);
    res_t r;
    r.data_byte      = d;
    r.has_data       = has;
    r.fin_flag       = fin_q;
    r.frame_opcode   = opc_q;
    r.was_masked     = masked_q;
    r.payload_length = len_acc;
    r.first_of_frame = first;
    r.last_of_frame  = last;
    return r;
  endfunction

  task automatic start_payload();
    pay_left = len_acc;
    key_idx  = 2'd0;
    first_q  = 1'b1;
    if (len_acc == 64'd0) begin
      made_res = make_result(8'd0, 1'b0, 1'b1, 1'b1);
      made     = 1'b1;
      phase    = ST_HEAD0;
    end else begin
      phase = ST_PAYLOAD;
    end
  endtask

  task automatic finish_length();
    if (masked_q) begin
      hdr_left = 4'd4;
      key_q    = 32'd0;
      phase    = ST_KEY;
    end else begin
      start_payload();
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [6:0] code;
    logic [7:0] k;
    logic       last;
    made = 1'b0;
    case (phase)
      ST_HEAD1: begin
        code     = b[6:0];
        masked_q = b[7];
        if (code == LEN16_CODE || code == LEN64_CODE) begin
          hdr_left = (code == LEN16_CODE) ? 4'd2 : 4'd8;
          len_acc  = 64'd0;
          phase    = ST_EXTLEN;
        end else begin
          len_acc = {57'd0, code};
          finish_length();
        end
      end
      ST_EXTLEN: begin
        len_acc  = {len_acc[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) finish_length();
      end
      ST_KEY: begin
        key_q    = {key_q[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) start_payload();
      end
      ST_PAYLOAD: begin
        k        = masked_q ? key_q[8 * (3 - int'(key_idx)) +: 8] : 8'd0;
        last     = (pay_left <= 64'd1);
        made_res = make_result(b ^ k, 1'b1, first_q, last);
        made     = 1'b1;
        first_q  = 1'b0;
        key_idx  = key_idx + 2'd1;
        if (pay_left != 64'd0) pay_left = pay_left - 64'd1;
        if (pay_left == 64'd0) phase = ST_HEAD0;
      end
      default: begin
        fin_q = b[7];
        opc_q = b[3:0];
        phase = ST_HEAD1;
      end
    endcase
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      phase    = ST_HEAD0;
      fin_q    = 1'b0;
      opc_q    = 4'd0;
      masked_q = 1'b0;
      len_acc  = 64'd0;
      hdr_left = 4'd0;
      key_q    = 32'd0;
      pay_left = 64'd0;
      key_idx  = 2'd0;
      first_q  = 1'b1;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual data_byte %0h has_data %0b",
                   $time, data_byte, has_data);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("data_byte", 64'(want.data_byte), 64'(data_byte));
          check_field("has_data", 64'(want.has_data), 64'(has_data));
          check_field("fin_flag", 64'(want.fin_flag), 64'(fin_flag));
          check_field("frame_opcode", 64'(want.frame_opcode), 64'(frame_opcode));
          check_field("was_masked", 64'(want.was_masked), 64'(was_masked));
          check_field("payload_length", want.payload_length, payload_length);
          check_field("first_of_frame", 64'(want.first_of_frame), 64'(first_of_frame));
          check_field("last_of_frame", 64'(want.last_of_frame), 64'(last_of_frame));
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_byte);
        if (made) pending_results = {pending_results, made_res};
      end
    end
    fail_count  <= mismatches;
    results_due <= pending_results.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the deframer bench: clock, reset, byte stream stimulus, receiver
// stalls and the verdict. Depends on wsd_pkg, websocket_frame_deframer.sv and wsd_frame_checker.sv.
module tb_top;
  import wsd_pkg::*;
  import wsd_ws_codes::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 8;

  typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_kind_e;
  typedef enum {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_PATTERN} rx_mode_e;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = 8'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  data_byte;
  logic        has_data;
  logic        fin_flag;
  logic [3:0]  frame_opcode;
  logic        was_masked;
  logic [63:0] payload_length;
  logic        first_of_frame;
  logic        last_of_frame;
  int          fail_count;
  int          results_due;

  int          cycles      = 0;
  int          sent_count  = 0;
  int          burst_left  = 0;
  bit          no_gaps     = 1'b0;
  int          hold_ask    = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  int          rx_cyc      = 0;
  rx_mode_e    rx_mode     = RX_ALWAYS;

  logic [7:0]  directed_seq[$] = '{
    8'h81, 8'h00,
    8'h89, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78,
    8'hFF, 8'h83, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hFF,
    8'h70, 8'h7E, 8'h00, 8'h02, 8'h00, 8'hFF
  };

  websocket_frame_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .has_data       (has_data),
    .fin_flag       (fin_flag),
    .frame_opcode   (frame_opcode),
    .was_masked     (was_masked),
    .payload_length (payload_length),
    .first_of_frame (first_of_frame),
    .last_of_frame  (last_of_frame)
  );

  wsd_frame_checker chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .has_data       (has_data),
    .fin_flag       (fin_flag),
    .frame_opcode   (frame_opcode),
    .was_masked     (was_masked),
    .payload_length (payload_length),
    .first_of_frame (first_of_frame),
    .last_of_frame  (last_of_frame),
    .fail_count     (fail_count),
    .results_due    (results_due)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stall the receiver: long hold on request, otherwise a mode picked at random
  always @(negedge clk) begin
    rx_cyc++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_cyc % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
        RX_MOSTLY: out_ready <= ($urandom_range(0, 4) != 0);
        default:   out_ready <= ((rx_cyc % 7) >= 3);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!no_gaps && burst_left <= 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_frame(input logic [7:0] head, input bit masked, input len_kind_e kind,
                            input logic [63:0] len, input logic [31:0] key, input int pay_n);
    send_byte(head);
    case (kind)
      LEN_SHORT: send_byte({masked, len[6:0]});
      LEN_EXT16: begin
        send_byte({masked, LEN16_CODE});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN64_CODE});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    end
    repeat (pay_n) send_byte(8'($urandom));
  endtask

  task automatic run_random(input int n);
    int        stop_at;
    int        pick;
    int        len;
    len_kind_e kind;
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        kind = LEN_SHORT;
        len  = $urandom_range(1, 12);
      end else if (pick < 63) begin
        kind = LEN_SHORT;
        len  = $urandom_range(13, 125);
      end else if (pick < 70) begin
        kind = LEN_SHORT;
        len  = 0;
      end else if (pick < 82) begin
        kind = LEN_EXT16;
        len  = $urandom_range(0, 24);
      end else if (pick < 94) begin
        kind = LEN_EXT64;
        len  = $urandom_range(0, 24);
      end else begin
        kind = LEN_EXT16;
        len  = $urandom_range(126, 400);
      end
      send_frame(8'($urandom), 1'($urandom), kind, 64'(len), $urandom, len);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed_seq[i]) send_byte(directed_seq[i]);
    run_random(250);
    wait_drained();
    // hold the receiver off while a long frame streams in without gaps
    no_gaps = 1'b1;
    hold_ask++;
    send_frame(8'h82, 1'b1, LEN_SHORT, 64'd120, $urandom, 120);
    no_gaps = 1'b0;
    send_frame(8'h02, 1'b1, LEN_EXT16, 64'd130, $urandom, 130);
    run_random(250);
    // leave the stream inside a frame whose length has every high bit set
    send_frame(8'($urandom), 1'b1, LEN_EXT64, {56'hFF_FFFF_FFFF_FFFF, 8'($urandom)},
               $urandom, 24);
    wait_drained();
    if (fail_count == 0 && results_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- websocket_frame_deframer.f -----
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_parser.sv
hw/rtl/wsd_out_buf.sv
hw/rtl/websocket_frame_deframer.sv
bench/wsd_frame_checker.sv
bench/tb_top.sv
